// ===== hdl/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types and codes for the ring buffer FIFO with counts.
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

  localparam int CNT_BITS = 8;
  localparam int CFG_BITS = 9;
  localparam int DATA_BITS = 32;

  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_COMMIT  = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_STATUS  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE     = 2'd0,
    STS_NO_SPACE = 2'd1,
    STS_NO_DATA  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_RESULT = 1'b1
  } state_t;

  // Result of one pointer step: memory strobes, status and counts after the step
  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    status_t             status;
    logic [CNT_BITS-1:0] write_contig;
    logic [CNT_BITS-1:0] write_avail;
    logic [CNT_BITS-1:0] read_contig;
    logic [CNT_BITS-1:0] read_avail;
  } ptr_res_t;

endpackage

`default_nettype wire

// ===== hdl/rbf_ptr.sv =====
// ----------------------------------------------------------------------------
// rbf_ptr
// Head/tail pointers and ring size; evaluates one command, updates the
// pointers on a transaction and reports status and counts after the step.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_ptr
  import rbf_pkg::*;
#(
  parameter int RING_DEPTH = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_BITS-1:0]          cfg_value,
  input  wire logic                         step,
  input  wire cmd_t                         cmd,
  input  wire logic [CNT_BITS-1:0]          count,
  output logic [$clog2(RING_DEPTH)-1:0]     head,
  output logic [$clog2(RING_DEPTH)-1:0]     tail,
  output ptr_res_t                          res
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int NW = $clog2(RING_DEPTH + 1);
  localparam int AW = ((NW > CFG_BITS) ? NW : CFG_BITS) + 1;
  localparam int NRST = (RING_DEPTH < 256) ? RING_DEPTH : 256;

  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [NW-1:0] n_r, n_nxt;

  logic [AW-1:0] n_w, h_w, t_w, hn_w, tn_w, cnt_w, cfg_w;
  logic [AW-1:0] wa_pre, ra_pre, h_adv, t_adv, h_one, t_one;
  logic [AW-1:0] wc_post, wa_post, rc_post, ra_post;

  function automatic logic [AW-1:0] f_wavail(logic [AW-1:0] h, logic [AW-1:0] t,
                                             logic [AW-1:0] n);
    if (t <= h) return n - h + t - AW'(1);
    return t - h - AW'(1);
  endfunction

  function automatic logic [AW-1:0] f_ravail(logic [AW-1:0] h, logic [AW-1:0] t,
                                             logic [AW-1:0] n);
    if (h >= t) return h - t;
    return n - t + h;
  endfunction

  function automatic logic [AW-1:0] f_adv(logic [AW-1:0] p, logic [AW-1:0] by,
                                          logic [AW-1:0] n);
    logic [AW-1:0] s;
    s = p + by;
    if (s >= n) s = s - n;
    return s;
  endfunction

  assign n_w   = AW'(n_r);
  assign h_w   = AW'(head_r);
  assign t_w   = AW'(tail_r);
  assign cnt_w = AW'(count);
  assign cfg_w = AW'(cfg_value);

  assign wa_pre = f_wavail(h_w, t_w, n_w);
  assign ra_pre = f_ravail(h_w, t_w, n_w);
  assign h_one  = f_adv(h_w, AW'(1), n_w);
  assign t_one  = f_adv(t_w, AW'(1), n_w);
  assign h_adv  = f_adv(h_w, cnt_w, n_w);
  assign t_adv  = f_adv(t_w, cnt_w, n_w);

  always_comb begin
    hn_w       = h_w;
    tn_w       = t_w;
    res.wr_en  = 1'b0;
    res.rd_en  = 1'b0;
    res.status = STS_DONE;
    case (cmd)
      CMD_PUSH: begin
        if (wa_pre == '0) begin
          res.status = STS_NO_SPACE;
        end else begin
          res.wr_en = 1'b1;
          hn_w      = h_one;
        end
      end
      CMD_POP: begin
        if (ra_pre == '0) begin
          res.status = STS_NO_DATA;
        end else begin
          res.rd_en = 1'b1;
          tn_w      = t_one;
        end
      end
      CMD_COMMIT: begin
        if (cnt_w > wa_pre) res.status = STS_NO_SPACE;
        else hn_w = h_adv;
      end
      CMD_RELEASE: begin
        if (cnt_w > ra_pre) res.status = STS_NO_DATA;
        else tn_w = t_adv;
      end
      CMD_CLEAR: begin
        tn_w = h_w;
      end
      default: begin
      end
    endcase

    if (tn_w <= hn_w) wc_post = n_w - hn_w - ((tn_w == '0) ? AW'(1) : AW'(0));
    else wc_post = tn_w - hn_w - AW'(1);
    if (hn_w >= tn_w) rc_post = hn_w - tn_w;
    else rc_post = n_w - tn_w;
    wa_post = f_wavail(hn_w, tn_w, n_w);
    ra_post = f_ravail(hn_w, tn_w, n_w);

    res.write_contig = wc_post[CNT_BITS-1:0];
    res.write_avail  = wa_post[CNT_BITS-1:0];
    res.read_contig  = rc_post[CNT_BITS-1:0];
    res.read_avail   = ra_post[CNT_BITS-1:0];
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    n_nxt    = n_r;
    if (cfg_we) begin
      head_nxt = '0;
      tail_nxt = '0;
      if (cfg_w < AW'(2)) n_nxt = NW'(2);
      else if (cfg_w > AW'(RING_DEPTH)) n_nxt = NW'(RING_DEPTH);
      else n_nxt = cfg_w[NW-1:0];
    end else if (step) begin
      head_nxt = hn_w[IW-1:0];
      tail_nxt = tn_w[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      n_r    <= NW'(NRST);
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      n_r    <= n_nxt;
    end
  end

  assign head = head_r;
  assign tail = tail_r;

`ifndef SYNTHESIS
  a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    AW'(head_r) < AW'(n_r))
    else $error("head outside ring");
  a_tail_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    AW'(tail_r) < AW'(n_r))
    else $error("tail outside ring");
  a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (head_r == '0) && (tail_r == '0))
    else $error("ring not emptied by size write");
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r >= NW'(2)) && (AW'(n_r) <= AW'(RING_DEPTH)))
    else $error("ring size out of range");
`endif

endmodule

`default_nettype wire

// ===== hdl/ring_buffer_fifo_with_counts.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_fifo_with_counts
// Circular FIFO with one slot kept empty; push, pop, commit, release, clear
// and status commands, each answered by one result with counts.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / tuser                      | one transaction
//  in_     | in  | tdata: data_in, count; tuser: cmd   | one command
//  out_    | out | tdata: read_data, status, counts    | one result
//  cfg_    | in  | tdata: slots_in_use                 | ring size write
//
//  Each command: accept (pointer update, memory access), then the
//  registered memory read data is merged into the output register.
//  A new command is taken while the previous result waits in out_.
//  A size write empties the ring; stored data is kept.
//  Synchronous active-low reset; no memory clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_fifo_with_counts
  import rbf_pkg::*;
#(
  parameter int RING_DEPTH   = 256,
  parameter int ELEMENT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // data_in[31:0], count[39:32]
  input  wire logic [2:0]  in_tuser,   // cmd[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // read_data[31:0], status[33:32],
                                       // write_contig[41:34], write_avail[49:42],
                                       // read_contig[57:50], read_avail[65:58]
  input  wire logic        cfg_tvalid,
  output logic             cfg_tready,
  input  wire logic [15:0] cfg_tdata   // slots_in_use[8:0]
);

  localparam int IW = $clog2(RING_DEPTH);

  state_t state_r, state_nxt;

  logic                    in_acc, cfg_we, load_out;
  logic [IW-1:0]           head, tail;
  ptr_res_t                res;
  ptr_res_t                res_r;
  logic [63:0]             din_ext, rd_ext;
  logic [ELEMENT_BITS-1:0] mem [RING_DEPTH];
  logic [ELEMENT_BITS-1:0] mem_q_r;
  logic [DATA_BITS-1:0]    read_data;
  logic                    out_valid_r;
  logic [71:0]             out_data_r;

  assign in_acc = in_tvalid && in_tready;
  assign cfg_we = cfg_tvalid && cfg_tready;

  rbf_ptr #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ptr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_value (cfg_tdata[CFG_BITS-1:0]),
    .step      (in_acc),
    .cmd       (cmd_t'(in_tuser)),
    .count     (in_tdata[39:32]),
    .head      (head),
    .tail      (tail),
    .res       (res)
  );

  // element store
  assign din_ext = 64'(in_tdata[DATA_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (in_acc && res.wr_en) begin
      mem[head] <= din_ext[ELEMENT_BITS-1:0];
    end
    if (in_acc && res.rd_en) begin
      mem_q_r <= mem[tail];
    end
  end

  // control FSM
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_RESULT;
      ST_RESULT: if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cfg_tready = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = !cfg_tvalid;
        cfg_tready = 1'b1;
      end
      ST_RESULT: begin
        load_out = !out_valid_r || out_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) res_r <= res;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign rd_ext    = 64'(mem_q_r);
  assign read_data = res_r.rd_en ? rd_ext[DATA_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {6'd0, res_r.read_avail, res_r.read_contig, res_r.write_avail,
                     res_r.write_contig, res_r.status, read_data};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
